### rtl/amkc_pkg.sv
// Shared types and constants for the appliance mode and key controller.
package amkc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int READING_W = 12;
    localparam int TICKS_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_RELEASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FLOOR        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SPLIT        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CEILING      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS      = 3'd7;

    // Key codes.
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_MODE  = 2'd1;
    localparam logic [1:0] KEY_POWER = 2'd2;

    // Colour outputs.
    localparam logic [2:0] COLOUR_OFF    = 3'd0;
    localparam logic [2:0] COLOUR_BLUE   = 3'd1;
    localparam logic [2:0] COLOUR_ORANGE = 3'd2;
    localparam logic [2:0] COLOUR_RED    = 3'd4;

    typedef struct packed {
        logic [READING_W-1:0] touch_threshold;
        logic [READING_W-1:0] battery_high_level;
        logic [READING_W-1:0] battery_release_level;
        logic [READING_W-1:0] key_floor;
        logic [READING_W-1:0] key_split;
        logic [READING_W-1:0] key_ceiling;
        logic [TICKS_W-1:0]   long_press_ticks;
        logic [TICKS_W-1:0]   short_press_ticks;
    } t_cfg;

    // One classified tick as it travels from the front to the back.
    typedef struct packed {
        logic                 charging;
        logic [READING_W-1:0] supply;
        logic [1:0]           key_code;
        logic                 touch_win;
        logic                 heat_win;
        logic [READING_W-1:0] touch_raw;
        logic [READING_W-1:0] heat_raw;
    } t_item;

endpackage

### rtl/appliance_mode_key_controller.sv
// Top level of the appliance mode and key controller.
//
// One input item is one 10 ms tick: the charger flag and four averaged ADC
// readings. Each item yields exactly one result item with the mode, power and
// battery levels, motor and heater enables, colour LEDs and charging flag.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The front latches the supply and key readings in their tick
// windows and classifies the key, then passes the item through a two-entry
// queue to the back, which runs the key, start and battery state and holds the
// result. An accepted item passes through the queue and then the result
// register, and the block takes one item per clock while the output side is
// not stalled. A stall on the output holds the result register; the queue
// then fills and o_stall rises after at most two more items.
// Configuration registers are written through i_cfg_valid/o_cfg_ready with
// i_cfg_index and i_cfg_data; o_cfg_ready is always high. Write them only
// while no item is in flight. Synchronous reset clears all state but the
// queue storage and o_charging, and loads the default thresholds.
module appliance_mode_key_controller #(
    parameter int QUEUE_DEPTH = amkc_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_charger_absent,
    input  logic [amkc_pkg::READING_W-1:0]     i_supply_reading,
    input  logic [amkc_pkg::READING_W-1:0]     i_key_reading,
    input  logic [amkc_pkg::READING_W-1:0]     i_touch_reading,
    input  logic [amkc_pkg::READING_W-1:0]     i_heat_reading,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [2:0]                         o_mode_level,
    output logic [1:0]                         o_power_level,
    output logic [1:0]                         o_battery_level,
    output logic                               o_motor_on,
    output logic                               o_heater_on,
    output logic [2:0]                         o_colour_leds,
    output logic                               o_charging,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [amkc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [amkc_pkg::READING_W-1:0]     i_cfg_data
);

    amkc_pkg::t_cfg  r_cfg;
    amkc_pkg::t_item front_item;
    amkc_pkg::t_item queue_item;
    logic            queue_full;
    logic            queue_valid;
    logic            push;
    logic            pop;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = queue_full;
    assign push        = i_valid && !queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.touch_threshold       <= 12'd1000;
            r_cfg.battery_high_level    <= 12'd921;
            r_cfg.battery_release_level <= 12'd910;
            r_cfg.key_floor             <= 12'd100;
            r_cfg.key_split             <= 12'd1536;
            r_cfg.key_ceiling           <= 12'd2048;
            r_cfg.long_press_ticks      <= 8'd200;
            r_cfg.short_press_ticks     <= 8'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                amkc_pkg::CFG_TOUCH_THRESHOLD: r_cfg.touch_threshold       <= i_cfg_data;
                amkc_pkg::CFG_BATTERY_HIGH:    r_cfg.battery_high_level    <= i_cfg_data;
                amkc_pkg::CFG_BATTERY_RELEASE: r_cfg.battery_release_level <= i_cfg_data;
                amkc_pkg::CFG_KEY_FLOOR:       r_cfg.key_floor             <= i_cfg_data;
                amkc_pkg::CFG_KEY_SPLIT:       r_cfg.key_split             <= i_cfg_data;
                amkc_pkg::CFG_KEY_CEILING:     r_cfg.key_ceiling           <= i_cfg_data;
                amkc_pkg::CFG_LONG_PRESS:      r_cfg.long_press_ticks      <= i_cfg_data[7:0];
                amkc_pkg::CFG_SHORT_PRESS:     r_cfg.short_press_ticks     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    amkc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_push           (push),
        .i_charger_absent (i_charger_absent),
        .i_supply_reading (i_supply_reading),
        .i_key_reading    (i_key_reading),
        .i_touch_reading  (i_touch_reading),
        .i_heat_reading   (i_heat_reading),
        .o_item           (front_item)
    );

    amkc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    amkc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (queue_valid),
        .i_item          (queue_item),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_mode_level    (o_mode_level),
        .o_power_level   (o_power_level),
        .o_battery_level (o_battery_level),
        .o_motor_on      (o_motor_on),
        .o_heater_on     (o_heater_on),
        .o_colour_leds   (o_colour_leds),
        .o_charging      (o_charging)
    );

endmodule

### rtl/amkc_front.sv
// Front part: tick window counter, supply and key latching, key classification.
module amkc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  amkc_pkg::t_cfg                       i_cfg,
    input  logic                                 i_push,
    input  logic                                 i_charger_absent,
    input  logic [amkc_pkg::READING_W-1:0]       i_supply_reading,
    input  logic [amkc_pkg::READING_W-1:0]       i_key_reading,
    input  logic [amkc_pkg::READING_W-1:0]       i_touch_reading,
    input  logic [amkc_pkg::READING_W-1:0]       i_heat_reading,
    output amkc_pkg::t_item                      o_item
);

    logic [4:0]                           r_window;
    logic [4:0]                           n_window;
    logic [amkc_pkg::READING_W-1:0]       r_supply;
    logic [amkc_pkg::READING_W-1:0]       n_supply;
    logic [amkc_pkg::READING_W-1:0]       r_key;
    logic [amkc_pkg::READING_W-1:0]       n_key;

    always_comb begin
        n_window = r_window;
        n_supply = r_supply;
        n_key    = r_key;
        // The window only moves on ticks without the charger.
        if (i_charger_absent) begin
            if (r_window >= 5'd30) begin
                n_window = 5'd0;
                n_supply = i_supply_reading;
            end else begin
                n_window = r_window + 5'd1;
            end
            if (n_window > 5'd10 && n_window < 5'd25) begin
                n_key = i_key_reading;
            end
        end

        o_item.charging  = ~i_charger_absent;
        o_item.supply    = n_supply;
        o_item.touch_win = (n_window < 5'd5);
        o_item.heat_win  = (n_window > 5'd28);
        o_item.touch_raw = i_touch_reading;
        o_item.heat_raw  = i_heat_reading;
        o_item.key_code  = amkc_pkg::KEY_NONE;
        if (n_key > i_cfg.key_floor && n_key < i_cfg.key_ceiling) begin
            o_item.key_code = (n_key > i_cfg.key_split) ? amkc_pkg::KEY_MODE
                                                         : amkc_pkg::KEY_POWER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_supply <= '0;
            r_key    <= '0;
        end else if (i_push) begin
            r_window <= n_window;
            r_supply <= n_supply;
            r_key    <= n_key;
        end
    end

endmodule

### rtl/amkc_queue.sv
// Short item queue between the front and the back.
module amkc_queue #(
    parameter int DEPTH = amkc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  amkc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output amkc_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    amkc_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/amkc_back.sv
// Back part: key events, start sequence, battery, motor and heater state, result register.
module amkc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  amkc_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  amkc_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [2:0]      o_mode_level,
    output logic [1:0]      o_power_level,
    output logic [1:0]      o_battery_level,
    output logic            o_motor_on,
    output logic            o_heater_on,
    output logic [2:0]      o_colour_leds,
    output logic            o_charging
);

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    logic [2:0]                     r_mode,    n_mode;
    logic [1:0]                     r_power,   n_power;
    logic [1:0]                     r_battery, n_battery;
    logic [3:0]                     r_step,    n_step;
    logic                           r_start,   n_start;
    logic [5:0]                     r_slow,    n_slow;
    logic [7:0]                     r_press,   n_press;
    logic                           r_long,    n_long;
    logic [1:0]                     r_last,    n_last;
    logic [amkc_pkg::READING_W-1:0] r_touch,   n_touch;
    logic [amkc_pkg::READING_W-1:0] r_heat,    n_heat;
    logic                           r_motor,   n_motor;
    logic                           r_heater,  n_heater;
    logic [2:0]                     r_colour,  n_colour;
    logic                           r_out_valid;
    logic                           r_charging;

    assign o_pop = i_valid && (!r_out_valid || !i_stall);

    always_comb begin
        logic [1:0]  ev;
        logic [13:0] heat3;
        logic [13:0] supply4;

        n_mode    = r_mode;
        n_power   = r_power;
        n_battery = r_battery;
        n_step    = r_step;
        n_start   = r_start;
        n_slow    = r_slow;
        n_press   = r_press;
        n_long    = r_long;
        n_last    = r_last;
        n_touch   = r_touch;
        n_heat    = r_heat;
        n_motor   = r_motor;
        n_heater  = r_heater;
        n_colour  = r_colour;
        ev        = EV_NONE;
        heat3     = '0;
        supply4   = {i_item.supply, 2'b00};

        if (i_item.charging) begin
            // Charging: rotating battery display, mode and power cleared, rest frozen.
            n_mode  = '0;
            n_power = '0;
            if (r_slow >= 6'd50) begin
                n_slow    = '0;
                n_battery = (r_battery >= 2'd2) ? 2'd0 : r_battery + 2'd1;
            end else begin
                n_slow = r_slow + 6'd1;
            end
        end else begin
            if (r_mode != '0 && !r_start) begin
                if (i_item.supply > i_cfg.battery_high_level) begin
                    n_battery = 2'd2;
                end else if (r_battery == 2'd2) begin
                    if (i_item.supply < i_cfg.battery_release_level) begin
                        n_battery = 2'd1;
                    end
                end else begin
                    n_battery = 2'd1;
                end
            end
            if (r_mode == '0 && !r_start) begin
                n_power   = '0;
                n_battery = '0;
                n_colour  = amkc_pkg::COLOUR_OFF;
            end

            // Press timing; the counter saturates at the long press length.
            if (i_item.key_code != amkc_pkg::KEY_NONE) begin
                n_last = i_item.key_code;
                if ({1'b0, r_press} + 9'd1 >= {1'b0, i_cfg.long_press_ticks}) begin
                    n_press = i_cfg.long_press_ticks;
                    if (!r_long) begin
                        n_long = 1'b1;
                        ev     = EV_LONG;
                    end
                end else begin
                    n_press = r_press + 8'd1;
                end
            end else if (r_press >= i_cfg.long_press_ticks) begin
                n_press = '0;
                n_long  = 1'b0;
            end else if (r_press >= i_cfg.short_press_ticks) begin
                n_press = '0;
                ev      = EV_SHORT;
            end else begin
                n_press = '0;
                n_last  = amkc_pkg::KEY_NONE;
            end

            if (ev == EV_SHORT && n_last == amkc_pkg::KEY_MODE) begin
                if (r_mode == '0) begin
                    n_power   = '0;
                    n_battery = '0;
                    n_start   = 1'b1;
                end else begin
                    n_mode  = (r_mode >= 3'd4) ? 3'd1 : r_mode + 3'd1;
                    n_power = 2'd1;
                end
            end else if (ev == EV_LONG && n_last == amkc_pkg::KEY_MODE) begin
                n_mode    = '0;
                n_power   = '0;
                n_start   = 1'b0;
                n_battery = '0;
            end else if (ev != EV_NONE && r_mode != '0) begin
                n_power = (n_power == 2'd3) ? 2'd1 : n_power + 2'd1;
            end

            if (!n_start) begin
                if (n_mode != '0) begin
                    if (i_item.touch_win) begin
                        n_touch = i_item.touch_raw;
                    end
                    if (n_touch < i_cfg.touch_threshold) begin
                        n_motor  = 1'b0;
                        n_heater = 1'b0;
                    end else begin
                        n_motor = 1'b1;
                        if (n_mode == 3'd2) begin
                            if (i_item.heat_win) begin
                                n_heat = i_item.heat_raw;
                            end
                            // heat > floor(4*supply/3) is the same as 3*heat > 4*supply.
                            heat3    = {2'b00, n_heat} + {1'b0, n_heat, 1'b0};
                            n_heater = !(heat3 > supply4);
                        end
                    end
                    if (n_touch > i_cfg.touch_threshold) begin
                        if (n_mode == 3'd1) begin
                            n_colour = amkc_pkg::COLOUR_BLUE;
                        end else if (n_mode == 3'd2) begin
                            n_colour = amkc_pkg::COLOUR_ORANGE;
                        end else begin
                            n_colour = amkc_pkg::COLOUR_RED;
                        end
                    end else begin
                        n_colour = amkc_pkg::COLOUR_OFF;
                    end
                end else begin
                    n_motor  = 1'b0;
                    n_heater = 1'b0;
                    n_step   = '0;
                    n_colour = amkc_pkg::COLOUR_OFF;
                end
            end else if (r_slow >= 6'd20) begin
                // Start sequence: one display step every 21 ticks.
                n_slow = '0;
                if (r_step < 4'd5) begin
                    n_mode    = 3'(4'd5 - r_step);
                    n_battery = '0;
                    n_power   = '0;
                end else if (r_step == 4'd5) begin
                    n_mode    = '0;
                    n_battery = '0;
                    n_power   = 2'd3;
                end else if (r_step == 4'd6) begin
                    n_mode    = '0;
                    n_power   = '0;
                    n_battery = 2'd2;
                end else if (r_step == 4'd7) begin
                    n_mode    = '0;
                    n_battery = '0;
                    n_power   = '0;
                    n_colour  = amkc_pkg::COLOUR_RED;
                end else if (r_step == 4'd8) begin
                    n_colour = amkc_pkg::COLOUR_ORANGE;
                end else if (r_step == 4'd9) begin
                    n_colour = amkc_pkg::COLOUR_BLUE;
                end
                if (r_step >= 4'd10) begin
                    n_colour = amkc_pkg::COLOUR_OFF;
                    n_step   = '0;
                    n_start  = 1'b0;
                    n_mode   = 3'd1;
                    n_power  = 2'd1;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end else begin
                n_slow = r_slow + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_power     <= '0;
            r_battery   <= '0;
            r_step      <= '0;
            r_start     <= 1'b0;
            r_slow      <= '0;
            r_press     <= '0;
            r_long      <= 1'b0;
            r_last      <= amkc_pkg::KEY_NONE;
            r_touch     <= '0;
            r_heat      <= '0;
            r_motor     <= 1'b0;
            r_heater    <= 1'b0;
            r_colour    <= amkc_pkg::COLOUR_OFF;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode    <= n_mode;
                r_power   <= n_power;
                r_battery <= n_battery;
                r_step    <= n_step;
                r_start   <= n_start;
                r_slow    <= n_slow;
                r_press   <= n_press;
                r_long    <= n_long;
                r_last    <= n_last;
                r_touch   <= n_touch;
                r_heat    <= n_heat;
                r_motor   <= n_motor;
                r_heater  <= n_heater;
                r_colour  <= n_colour;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_charging <= i_item.charging;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_mode_level    = r_mode;
    assign o_power_level   = r_power;
    assign o_battery_level = r_battery;
    assign o_motor_on      = r_motor;
    assign o_heater_on     = r_heater;
    assign o_colour_leds   = r_colour;
    assign o_charging      = r_charging;

endmodule

### verif/amkc_tick_scoreboard.sv
// Tick scoreboard: predicts the controller's panel outputs per tick and checks them in order.
package amkc_tb_pkg;

    typedef struct packed {
        logic                           charger_absent;
        logic [amkc_pkg::READING_W-1:0] supply;
        logic [amkc_pkg::READING_W-1:0] key;
        logic [amkc_pkg::READING_W-1:0] touch;
        logic [amkc_pkg::READING_W-1:0] heat;
    } t_tick_item;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] power;
        logic [1:0] battery;
        logic       motor;
        logic       heater;
        logic [2:0] colour;
        logic       charging;
    } t_panel_state;

    typedef enum logic [1:0] {PRESS_NONE, PRESS_SHORT, PRESS_LONG} t_press;

    class t_tick_scoreboard;
        amkc_pkg::t_cfg                 cfg;
        logic [2:0]                     mode;
        logic [1:0]                     power;
        logic [1:0]                     battery;
        logic [3:0]                     start_step;
        logic                           start_active;
        logic [5:0]                     slow_ticks;
        logic [4:0]                     window;
        logic [7:0]                     press_ticks;
        logic                           long_seen;
        logic [1:0]                     last_key;
        logic [amkc_pkg::READING_W-1:0] held_supply;
        logic [amkc_pkg::READING_W-1:0] held_key;
        logic [amkc_pkg::READING_W-1:0] held_touch;
        logic [amkc_pkg::READING_W-1:0] held_heat;
        logic                           motor;
        logic                           heater;
        logic [2:0]                     colour;
        t_panel_state                   awaited_panels[$];
        int unsigned                    mismatches;
        int unsigned                    ticks_noted;
        int unsigned                    panels_checked;
        int unsigned                    starts_done;
        int unsigned                    short_presses;
        int unsigned                    long_presses;
        int unsigned                    charge_ticks;

        function new();
            cfg.touch_threshold       = 12'd1000;
            cfg.battery_high_level    = 12'd921;
            cfg.battery_release_level = 12'd910;
            cfg.key_floor             = 12'd100;
            cfg.key_split             = 12'd1536;
            cfg.key_ceiling           = 12'd2048;
            cfg.long_press_ticks      = 8'd200;
            cfg.short_press_ticks     = 8'd8;
            mode = '0;
            power = '0;
            battery = '0;
            start_step = '0;
            start_active = 1'b0;
            slow_ticks = '0;
            window = '0;
            press_ticks = '0;
            long_seen = 1'b0;
            last_key = amkc_pkg::KEY_NONE;
            held_supply = '0;
            held_key = '0;
            held_touch = '0;
            held_heat = '0;
            motor = 1'b0;
            heater = 1'b0;
            colour = amkc_pkg::COLOUR_OFF;
            mismatches = 0;
            ticks_noted = 0;
            panels_checked = 0;
            starts_done = 0;
            short_presses = 0;
            long_presses = 0;
            charge_ticks = 0;
        endfunction

        function void write_cfg(logic [amkc_pkg::CFG_IDX_W-1:0] idx,
                                logic [amkc_pkg::READING_W-1:0] data);
            case (idx)
                amkc_pkg::CFG_TOUCH_THRESHOLD: cfg.touch_threshold = data;
                amkc_pkg::CFG_BATTERY_HIGH:    cfg.battery_high_level = data;
                amkc_pkg::CFG_BATTERY_RELEASE: cfg.battery_release_level = data;
                amkc_pkg::CFG_KEY_FLOOR:       cfg.key_floor = data;
                amkc_pkg::CFG_KEY_SPLIT:       cfg.key_split = data;
                amkc_pkg::CFG_KEY_CEILING:     cfg.key_ceiling = data;
                amkc_pkg::CFG_LONG_PRESS:      cfg.long_press_ticks = data[amkc_pkg::TICKS_W-1:0];
                amkc_pkg::CFG_SHORT_PRESS:     cfg.short_press_ticks = data[amkc_pkg::TICKS_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return awaited_panels.size();
        endfunction

        function t_press key_event(logic [1:0] key);
            if (key != amkc_pkg::KEY_NONE) begin
                last_key = key;
                // The counter saturates at the long threshold; the long event fires once.
                if (int'(press_ticks) + 1 >= int'(cfg.long_press_ticks)) begin
                    press_ticks = cfg.long_press_ticks;
                    if (!long_seen) begin
                        long_seen = 1'b1;
                        return PRESS_LONG;
                    end
                end else begin
                    press_ticks = press_ticks + 8'd1;
                end
                return PRESS_NONE;
            end
            if (press_ticks >= cfg.long_press_ticks) begin
                press_ticks = '0;
                long_seen = 1'b0;
                return PRESS_NONE;
            end
            if (press_ticks >= cfg.short_press_ticks) begin
                press_ticks = '0;
                return PRESS_SHORT;
            end
            press_ticks = '0;
            last_key = amkc_pkg::KEY_NONE;
            return PRESS_NONE;
        endfunction

        function void bump_power();
            power = (power == 2'd3) ? 2'd1 : power + 2'd1;
        endfunction

        function void keys_and_battery(t_tick_item t);
            logic [1:0] key;
            t_press     ev;
            window = window + 5'd1;
            if (window > 5'd30) begin
                window = '0;
                held_supply = t.supply;
            end
            if (mode != 3'd0 && !start_active) begin
                if (held_supply > cfg.battery_high_level)
                    battery = 2'd2;
                else if (battery == 2'd2) begin
                    if (held_supply < cfg.battery_release_level)
                        battery = 2'd1;
                end else
                    battery = 2'd1;
            end
            if (mode == 3'd0 && !start_active) begin
                power = '0;
                battery = '0;
                colour = amkc_pkg::COLOUR_OFF;
            end
            if (window > 5'd10 && window < 5'd25)
                held_key = t.key;
            key = amkc_pkg::KEY_NONE;
            if (held_key > cfg.key_floor && held_key < cfg.key_ceiling)
                key = (held_key > cfg.key_split) ? amkc_pkg::KEY_MODE : amkc_pkg::KEY_POWER;
            ev = key_event(key);
            if (ev == PRESS_SHORT) begin
                short_presses++;
                if (last_key == amkc_pkg::KEY_MODE) begin
                    if (mode == 3'd0) begin
                        power = '0;
                        battery = '0;
                        start_active = 1'b1;
                    end else begin
                        mode = (mode >= 3'd4) ? 3'd1 : mode + 3'd1;
                        power = 2'd1;
                    end
                end else if (mode != 3'd0) begin
                    bump_power();
                end
            end else if (ev == PRESS_LONG) begin
                long_presses++;
                if (last_key == amkc_pkg::KEY_MODE) begin
                    mode = '0;
                    power = '0;
                    start_active = 1'b0;
                    battery = '0;
                end else if (mode != 3'd0) begin
                    bump_power();
                end
            end
        endfunction

        function void drive_outputs(t_tick_item t);
            if (window < 5'd5)
                held_touch = t.touch;
            if (held_touch < cfg.touch_threshold) begin
                motor = 1'b0;
                heater = 1'b0;
            end else begin
                motor = 1'b1;
                if (mode == 3'd2) begin
                    if (window > 5'd28)
                        held_heat = t.heat;
                    heater = (int'(held_heat) > (int'(held_supply) * 4) / 3) ? 1'b0 : 1'b1;
                end
            end
            // A touch exactly at the threshold runs the motor but leaves the colours dark.
            if (held_touch > cfg.touch_threshold) begin
                if (mode == 3'd1)
                    colour = amkc_pkg::COLOUR_BLUE;
                else if (mode == 3'd2)
                    colour = amkc_pkg::COLOUR_ORANGE;
                else if (mode > 3'd2)
                    colour = amkc_pkg::COLOUR_RED;
            end else begin
                colour = amkc_pkg::COLOUR_OFF;
            end
        endfunction

        function void step_start_show();
            slow_ticks = slow_ticks + 6'd1;
            if (slow_ticks <= 6'd20)
                return;
            slow_ticks = '0;
            if (start_step < 4'd5) begin
                mode = 3'(5 - start_step);
                battery = '0;
                power = '0;
            end else if (start_step == 4'd5) begin
                mode = '0;
                battery = '0;
                power = 2'd3;
            end else if (start_step == 4'd6) begin
                mode = '0;
                power = '0;
                battery = 2'd2;
            end else if (start_step == 4'd7) begin
                mode = '0;
                battery = '0;
                power = '0;
                colour = amkc_pkg::COLOUR_RED;
            end else if (start_step == 4'd8) begin
                colour = amkc_pkg::COLOUR_ORANGE;
            end else if (start_step == 4'd9) begin
                colour = amkc_pkg::COLOUR_BLUE;
            end
            start_step = start_step + 4'd1;
            if (start_step > 4'd10) begin
                colour = amkc_pkg::COLOUR_OFF;
                start_step = '0;
                start_active = 1'b0;
                mode = 3'd1;
                power = 2'd1;
                slow_ticks = '0;
                starts_done++;
            end
        endfunction

        function t_panel_state advance_tick(t_tick_item t);
            t_panel_state p;
            if (!t.charger_absent) begin
                // Charging: mode, power zeroed; keys, rest held; battery display rotates.
                charge_ticks++;
                mode = '0;
                power = '0;
                slow_ticks = slow_ticks + 6'd1;
                if (slow_ticks > 6'd50) begin
                    slow_ticks = '0;
                    battery = (battery >= 2'd2) ? 2'd0 : battery + 2'd1;
                end
            end else begin
                keys_and_battery(t);
                if (start_active)
                    step_start_show();
                else if (mode != 3'd0)
                    drive_outputs(t);
                else begin
                    motor = 1'b0;
                    heater = 1'b0;
                    start_step = '0;
                    colour = amkc_pkg::COLOUR_OFF;
                end
            end
            p.mode = mode;
            p.power = power;
            p.battery = battery;
            p.motor = motor;
            p.heater = heater;
            p.colour = colour;
            p.charging = !t.charger_absent;
            return p;
        endfunction

        function void note_tick(t_tick_item t);
            ticks_noted++;
            awaited_panels.push_back(advance_tick(t));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_panel(t_panel_state got);
            t_panel_state want;
            if (awaited_panels.size() == 0) begin
                $error("result item arrived with no tick outstanding");
                mismatches++;
                return;
            end
            want = awaited_panels.pop_front();
            panels_checked++;
            compare_field("mode_level", 8'(want.mode), 8'(got.mode));
            compare_field("power_level", 8'(want.power), 8'(got.power));
            compare_field("battery_level", 8'(want.battery), 8'(got.battery));
            compare_field("motor_on", 8'(want.motor), 8'(got.motor));
            compare_field("heater_on", 8'(want.heater), 8'(got.heater));
            compare_field("colour_leds", 8'(want.colour), 8'(got.colour));
            compare_field("charging", 8'(want.charging), 8'(got.charging));
        endfunction
    endclass

endpackage

### verif/appliance_mode_key_controller_tb.sv
// Testbench top: drives ticks and settings into the controller and checks every panel result.
module appliance_mode_key_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 80;

    // Idling phases of the run.
    localparam int PHASE_SLOW_RECEIVER = 0;
    localparam int PHASE_SLOW_SENDER   = 1;
    localparam int PHASE_FULL_RATE     = 2;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic                           i_charger_absent;
    logic [amkc_pkg::READING_W-1:0] i_supply_reading;
    logic [amkc_pkg::READING_W-1:0] i_key_reading;
    logic [amkc_pkg::READING_W-1:0] i_touch_reading;
    logic [amkc_pkg::READING_W-1:0] i_heat_reading;
    logic                           o_valid;
    logic                           i_stall;
    logic [2:0]                     o_mode_level;
    logic [1:0]                     o_power_level;
    logic [1:0]                     o_battery_level;
    logic                           o_motor_on;
    logic                           o_heater_on;
    logic [2:0]                     o_colour_leds;
    logic                           o_charging;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [amkc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [amkc_pkg::READING_W-1:0] i_cfg_data;

    amkc_tb_pkg::t_tick_scoreboard sb = new();
    int          idle_mode;
    bit          hold_request;
    bit          hold_done;
    int unsigned hold_left;
    int unsigned cycle_count;
    int unsigned settings_applied;

    appliance_mode_key_controller uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_charger_absent (i_charger_absent),
        .i_supply_reading (i_supply_reading),
        .i_key_reading    (i_key_reading),
        .i_touch_reading  (i_touch_reading),
        .i_heat_reading   (i_heat_reading),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mode_level     (o_mode_level),
        .o_power_level    (o_power_level),
        .o_battery_level  (o_battery_level),
        .o_motor_on       (o_motor_on),
        .o_heater_on      (o_heater_on),
        .o_colour_leds    (o_colour_leds),
        .o_charging       (o_charging),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bit sender_rests();
        case (idle_mode)
            PHASE_SLOW_RECEIVER: return $urandom_range(99) < 16;
            PHASE_SLOW_SENDER:   return $urandom_range(99) < 87;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_rests();
        case (idle_mode)
            PHASE_SLOW_RECEIVER: return $urandom_range(99) < 87;
            PHASE_SLOW_SENDER:   return $urandom_range(99) < 16;
            default: return 1'b0;
        endcase
    endfunction

    // The receiver's stall, including one long hold-off that lets the block back up.
    initial begin
        i_stall = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= receiver_rests();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_panel({o_mode_level, o_power_level, o_battery_level, o_motor_on,
                            o_heater_on, o_colour_leds, o_charging});
    end

    function automatic logic [amkc_pkg::READING_W-1:0] clip12(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return 12'd4095;
        return v[amkc_pkg::READING_W-1:0];
    endfunction

    function automatic logic [amkc_pkg::READING_W-1:0] near(int centre);
        return clip12(centre + int'($urandom_range(4)) - 2);
    endfunction

    function automatic amkc_tb_pkg::t_tick_item mk(logic ca, int s, int k, int t, int h);
        amkc_tb_pkg::t_tick_item it;
        it.charger_absent = ca;
        it.supply = clip12(s);
        it.key = clip12(k);
        it.touch = clip12(t);
        it.heat = clip12(h);
        return it;
    endfunction

    // A key reading of the given class under the current thresholds.
    function automatic logic [amkc_pkg::READING_W-1:0] key_value(logic [1:0] kind);
        int lo;
        int hi;
        int fl;
        int sp;
        int ce;
        fl = int'(sb.cfg.key_floor);
        sp = int'(sb.cfg.key_split);
        ce = int'(sb.cfg.key_ceiling);
        if (kind == amkc_pkg::KEY_NONE) begin
            case ($urandom_range(2))
                0: return 12'($urandom_range(fl, 0));
                1: return 12'($urandom_range(4095, ce));
                default: return '0;
            endcase
        end
        lo = (kind == amkc_pkg::KEY_MODE) ? ((sp > fl) ? sp : fl) + 1 : fl + 1;
        hi = (kind == amkc_pkg::KEY_MODE) ? ce - 1 : ((sp < ce - 1) ? sp : ce - 1);
        if (lo > hi)
            return 12'($urandom_range(4095));
        case ($urandom_range(9))
            0: return lo[amkc_pkg::READING_W-1:0];
            1: return hi[amkc_pkg::READING_W-1:0];
            default: return 12'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic logic [amkc_pkg::READING_W-1:0] pick_supply();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return near(int'(sb.cfg.battery_high_level));
        if (r < 65)
            return near(int'(sb.cfg.battery_release_level));
        return 12'($urandom_range(4095));
    endfunction

    function automatic logic [amkc_pkg::READING_W-1:0] pick_touch();
        if ($urandom_range(1) == 0)
            return near(int'(sb.cfg.touch_threshold));
        return 12'($urandom_range(4095));
    endfunction

    // Heat readings cluster around the heater cut-off for the supply in use.
    function automatic logic [amkc_pkg::READING_W-1:0] pick_heat(
        logic [amkc_pkg::READING_W-1:0] sup);
        if ($urandom_range(1) == 0)
            return near((int'(sup) * 4) / 3);
        return 12'($urandom_range(4095));
    endfunction

    function automatic int press_length(bit mode_key);
        int r;
        int lp;
        int sp;
        lp = int'(sb.cfg.long_press_ticks);
        sp = int'(sb.cfg.short_press_ticks);
        if (sp > lp)
            sp = lp;
        r = $urandom_range(99);
        if (r < 10)
            return $urandom_range(6, 1);
        if (r < (lp > 60 ? 18 : (mode_key ? 25 : 45)))
            return $urandom_range(lp + 40, lp + 14);
        return $urandom_range(sp + 30, sp + 14);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_tick(input amkc_tb_pkg::t_tick_item t);
        while (sender_rests()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_charger_absent <= t.charger_absent;
        i_supply_reading <= t.supply;
        i_key_reading <= t.key;
        i_touch_reading <= t.touch;
        i_heat_reading <= t.heat;
        do @(posedge i_clk); while (o_stall);
        sb.note_tick(t);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [amkc_pkg::CFG_IDX_W-1:0] idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data[amkc_pkg::READING_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_cfg(idx, data[amkc_pkg::READING_W-1:0]);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input int touch, input int bat_hi, input int bat_rel,
                                  input int k_floor, input int k_split, input int k_ceil,
                                  input int long_t, input int short_t);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        write_reg(amkc_pkg::CFG_TOUCH_THRESHOLD, touch);
        write_reg(amkc_pkg::CFG_BATTERY_HIGH, bat_hi);
        write_reg(amkc_pkg::CFG_BATTERY_RELEASE, bat_rel);
        write_reg(amkc_pkg::CFG_KEY_FLOOR, k_floor);
        write_reg(amkc_pkg::CFG_KEY_SPLIT, k_split);
        write_reg(amkc_pkg::CFG_KEY_CEILING, k_ceil);
        write_reg(amkc_pkg::CFG_LONG_PRESS, long_t);
        write_reg(amkc_pkg::CFG_SHORT_PRESS, short_t);
        settings_applied++;
    endtask

    task automatic random_settings(input bit ordered_release);
        int fl;
        int sp;
        int hi;
        int rel;
        fl = $urandom_range(600, 50);
        sp = fl + int'($urandom_range(1500, 200));
        hi = $urandom_range(4095);
        rel = ordered_release ? int'(clip12(hi - int'($urandom_range(40))))
                              : int'($urandom_range(4095));
        apply_settings($urandom_range(4095), hi, rel,
                       fl, sp, sp + int'($urandom_range(1500, 200)),
                       $urandom_range(60, 10), $urandom_range(8, 1));
    endtask

    // Mostly press-and-release sequences with steady readings, plus idle, charging and noise.
    task automatic run_episodes(input int unsigned target);
        int unsigned sent;
        int          kind;
        int          len;
        int          gap;
        int          n;
        bit          mode_key;
        logic [amkc_pkg::READING_W-1:0] sup;
        logic [amkc_pkg::READING_W-1:0] tch;
        logic [amkc_pkg::READING_W-1:0] kv;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(99);
            sup = pick_supply();
            tch = pick_touch();
            if (kind < 55) begin
                mode_key = $urandom_range(99) < 40;
                kv = key_value(mode_key ? amkc_pkg::KEY_MODE : amkc_pkg::KEY_POWER);
                len = press_length(mode_key);
                // A short release may miss the key window and merge two presses.
                gap = ($urandom_range(9) < 2) ? $urandom_range(15, 1) : $urandom_range(40, 18);
                for (n = 0; n < len; n++)
                    send_tick(mk(1'b1, int'(sup), int'(kv), int'(tch),
                                 int'(pick_heat(sup))));
                for (n = 0; n < gap; n++)
                    send_tick(mk(1'b1, int'(sup), int'(key_value(amkc_pkg::KEY_NONE)),
                                 int'(tch), int'(pick_heat(sup))));
                sent += len + gap;
            end else if (kind < 70) begin
                len = $urandom_range(60, 20);
                for (n = 0; n < len; n++)
                    send_tick(mk(1'b1, int'(sup), int'(key_value(amkc_pkg::KEY_NONE)),
                                 int'(tch), int'(pick_heat(sup))));
                sent += len;
            end else if (kind < 80) begin
                len = $urandom_range(120, 30);
                for (n = 0; n < len; n++)
                    send_tick(mk(1'b0, int'(sup), $urandom_range(4095), int'(tch),
                                 int'(pick_heat(sup))));
                sent += len;
            end else begin
                len = $urandom_range(20, 5);
                for (n = 0; n < len; n++)
                    send_tick(mk($urandom_range(9) != 0, $urandom_range(4095),
                                 $urandom_range(4095), $urandom_range(4095),
                                 $urandom_range(4095)));
                sent += len;
            end
        end
    endtask

    initial begin
        int fl;
        int sp;
        int ce;
        int th;
        int bh;
        int br;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_charger_absent = 1'b1;
        i_supply_reading = '0;
        i_key_reading = '0;
        i_touch_reading = '0;
        i_heat_reading = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_mode = PHASE_SLOW_RECEIVER;
        hold_request = 1'b0;
        settings_applied = 1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        fl = int'(sb.cfg.key_floor);
        sp = int'(sb.cfg.key_split);
        ce = int'(sb.cfg.key_ceiling);
        th = int'(sb.cfg.touch_threshold);
        bh = int'(sb.cfg.battery_high_level);
        br = int'(sb.cfg.battery_release_level);
        send_tick(mk(1'b1, 0, 0, 0, 0));
        send_tick(mk(1'b1, 4095, 4095, 4095, 4095));
        send_tick(mk(1'b0, 4095, 4095, 4095, 4095));
        send_tick(mk(1'b0, 0, 0, 0, 0));
        send_tick(mk(1'b1, bh, fl, th - 1, 0));
        send_tick(mk(1'b1, bh + 1, fl + 1, th, 4095));
        send_tick(mk(1'b1, br, sp, th + 1, 0));
        send_tick(mk(1'b1, br - 1, sp + 1, th, 4095));
        send_tick(mk(1'b1, 4095, ce - 1, 4095, 0));
        send_tick(mk(1'b1, 0, ce, 0, 4095));
        send_tick(mk(1'b0, bh, sp + 1, th + 1, 0));
        send_tick(mk(1'b1, bh + 1, fl + 1, th - 1, 4095));
        send_tick(mk(1'b1, br - 1, 4095, th, 2048));
        send_tick(mk(1'b1, 2048, 2048, 2048, 2048));
        send_tick(mk(1'b0, 1365, 2730, 1365, 2730));
        send_tick(mk(1'b1, 2730, 1365, 2730, 1365));
        run_episodes(300);

        apply_settings(1200, 2000, 1900, 100, 1536, 2048, 30, 4);
        run_episodes(330);

        idle_mode = PHASE_SLOW_SENDER;
        apply_settings(0, 0, 0, 0, 2047, 4095, 255, 1);
        run_episodes(330);
        apply_settings(4095, 4095, 4095, 0, 1000, 4095, 1, 255);
        run_episodes(330);

        idle_mode = PHASE_FULL_RATE;
        random_settings(1'b1);
        run_episodes(330);
        random_settings(1'b0);
        hold_request = 1'b1;
        run_episodes(330);

        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.mismatches++;
        end
        $display("Run covered %0d ticks under %0d threshold settings, %0d of them charging.",
                 sb.ticks_noted, settings_applied, sb.charge_ticks);
        $display("Seen: %0d short presses, %0d long presses, %0d completed start sequences.",
                 sb.short_presses, sb.long_presses, sb.starts_done);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
rtl/amkc_pkg.sv
rtl/amkc_front.sv
rtl/amkc_queue.sv
rtl/amkc_back.sv
rtl/appliance_mode_key_controller.sv
verif/amkc_tick_scoreboard.sv
verif/appliance_mode_key_controller_tb.sv
